// File: sv/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and branch codes for the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    // branch codes reported on the result word
    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_M00   = 2'd1;
    localparam logic [1:0] CASE_M11   = 2'd2;
    localparam logic [1:0] CASE_M22   = 2'd3;

    // pipeline advance and word-valid into a stage chain
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// File: sv/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module rmq_isqrt #(
    parameter int RAD_W = 32,
    parameter int SB_W  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rmq_pkg::t_stage_ctl     i_ctl,
    input  logic [RAD_W-1:0]        i_rad,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_valid,
    output logic [RAD_W/2-1:0]      o_root,
    output logic [SB_W-1:0]         o_sb
);
    localparam int RW = RAD_W / 2;

    logic             r_valid [1:RW];
    logic [RW+1:0]    r_rem   [1:RW];
    logic [RW-1:0]    r_root  [1:RW];
    logic [RAD_W-1:0] r_rad   [1:RW];
    logic [SB_W-1:0]  r_sb    [1:RW];

    for (genvar j = 0; j < RW; j++) begin : g_st
        logic             v_in;
        logic [RW+1:0]    rem_in;
        logic [RW-1:0]    root_in;
        logic [RAD_W-1:0] rad_in;
        logic [SB_W-1:0]  sb_in;
        logic [RW+1:0]    rem2;
        logic [RW+1:0]    trial;
        logic             ge;
        logic [RW+1:0]    n_rem;
        logic [RW-1:0]    n_root;

        if (j == 0) begin : g_first
            assign v_in    = i_ctl.valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign v_in    = r_valid[j];
            assign rem_in  = r_rem[j];
            assign root_in = r_root[j];
            assign rad_in  = r_rad[j];
            assign sb_in   = r_sb[j];
        end

        // bring down the next radicand bit pair and try root*4+1
        assign rem2   = {rem_in[RW-1:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem2 >= trial);
        assign n_rem  = ge ? (rem2 - trial) : rem2;
        assign n_root = {root_in[RW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[j+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[j+1]  <= n_rem;
                r_root[j+1] <= n_root;
                r_rad[j+1]  <= {rad_in[RAD_W-3:0], 2'b00};
                r_sb[j+1]   <= sb_in;
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_sb    = r_sb[RW];

endmodule

// File: sv/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// pipelined restoring divider, several lanes over one shared divisor
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int LANES = 4,
    parameter int SB_W  = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rmq_pkg::t_stage_ctl               i_ctl,
    input  logic [LANES-1:0][NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]                  i_den,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_valid,
    output logic [LANES-1:0][NUM_W-1:0]       o_quo,
    output logic [SB_W-1:0]                   o_sb
);
    logic                          r_valid [1:NUM_W];
    logic [LANES-1:0][DEN_W-1:0]   r_rem   [1:NUM_W];
    logic [LANES-1:0][NUM_W-1:0]   r_num   [1:NUM_W];
    logic [DEN_W-1:0]              r_den   [1:NUM_W];
    logic [SB_W-1:0]               r_sb    [1:NUM_W];

    for (genvar j = 0; j < NUM_W; j++) begin : g_st
        logic                        v_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][NUM_W-1:0] num_in;
        logic [DEN_W-1:0]            den_in;
        logic [SB_W-1:0]             sb_in;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][NUM_W-1:0] n_num;

        if (j == 0) begin : g_first
            assign v_in   = i_ctl.valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_valid[j];
            assign rem_in = r_rem[j];
            assign num_in = r_num[j];
            assign den_in = r_den[j];
            assign sb_in  = r_sb[j];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] rem2;
            logic [DEN_W:0] diff;
            logic           ge;
            assign rem2 = {rem_in[l], num_in[l][NUM_W-1]};
            assign diff = rem2 - {1'b0, den_in};
            assign ge   = (rem2 >= {1'b0, den_in});
            assign n_rem[l] = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            // quotient bits shift in where dividend bits leave
            assign n_num[l] = {num_in[l][NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[j+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[j+1] <= n_rem;
                r_num[j+1] <= n_num;
                r_den[j+1] <= den_in;
                r_sb[j+1]  <= sb_in;
            end
        end
    end

    assign o_valid = r_valid[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_sb    = r_sb[NUM_W];

endmodule

// File: sv/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to unit quaternion, fixed point, fully pipelined
// ----------------------------------------------------------------------------
// takes one matrix word per cycle and returns one quaternion word per matrix,
// in order. the words pass a front register, RW = (AW + FRAC_BITS + 1) / 2
// square root stages (one root bit per stage), where AW = max(DATA_WIDTH,
// FRAC_BITS + 1) + 2, then NW = DATA_WIDTH + FRAC_BITS + 2 divider stages
// (one quotient bit per stage) and an output register. throughput is one
// word per cycle while the output side takes words; a stall on the output
// freezes the whole pipeline. the trace branch is used when the trace is
// positive, otherwise the largest diagonal element picks the branch with ties
// going to the later one. a root argument that is not positive gives a zero
// quaternion with the degenerate flag set; every component saturates.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, low bits first
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // quat_w quat_x quat_y quat_z, low bits first
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      o_m_tdata,
    // case_taken[1:0], degenerate[2]
    output logic [2:0]                             o_m_tuser
);
    localparam int DW     = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int AW     = ((DW > F + 1) ? DW : F + 1) + 2;   // root argument magnitude
    localparam int SW     = AW + 1;                             // signed argument
    localparam int RW     = (AW + F + 1) / 2;                   // root width
    localparam int RAD_W  = 2 * RW;
    localparam int NUM_W  = DW + F + 2;
    localparam int DEN_W  = RW + 1;
    localparam int DDW    = DW + 1;                             // sum/difference width
    localparam int SQ_SB  = 3 + 4 * DDW;
    localparam int DV_SB  = 7 + RW;
    localparam int OUT_TD = ((4*DW+7)/8)*8;

    localparam logic signed [SW-1:0] ONE = SW'(1) << F;
    localparam logic [NUM_W-1:0] POS_MAX = NUM_W'((1 << (DW - 1)) - 1);
    localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(1) << (DW - 1);

    // the whole pipeline moves together
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- front stage: branch pick, root argument, differences
    logic signed [DW-1:0] m [9];
    for (genvar k = 0; k < 9; k++) begin : g_unpack
        assign m[k] = i_s_tdata[k*DW +: DW];
    end

    logic signed [SW-1:0]  e00, e11, e22, trace, arg;
    logic signed [DDW-1:0] d [4];
    logic [1:0]            sel;
    logic                  degen;
    logic [RAD_W-1:0]      rad;

    function automatic logic signed [DDW-1:0] f_sub(logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b);
        return DDW'(a) - DDW'(b);
    endfunction

    function automatic logic signed [DDW-1:0] f_add(logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b);
        return DDW'(a) + DDW'(b);
    endfunction

    always_comb begin
        e00   = SW'(m[0]);
        e11   = SW'(m[4]);
        e22   = SW'(m[8]);
        trace = e00 + e11 + e22;
        for (int k = 0; k < 4; k++) d[k] = '0;
        if (trace > 0) begin
            sel  = rmq_pkg::CASE_TRACE;
            arg  = ONE + trace;
            d[1] = f_sub(m[7], m[5]);
            d[2] = f_sub(m[2], m[6]);
            d[3] = f_sub(m[3], m[1]);
        end else if (e00 > e11 && e00 > e22) begin
            sel  = rmq_pkg::CASE_M00;
            arg  = ONE + e00 - e11 - e22;
            d[0] = f_sub(m[7], m[5]);
            d[2] = f_add(m[1], m[3]);
            d[3] = f_add(m[2], m[6]);
        end else if (e11 > e22) begin
            sel  = rmq_pkg::CASE_M11;
            arg  = ONE + e11 - e00 - e22;
            d[0] = f_sub(m[2], m[6]);
            d[1] = f_add(m[1], m[3]);
            d[3] = f_add(m[5], m[7]);
        end else begin
            sel  = rmq_pkg::CASE_M22;
            arg  = ONE + e22 - e00 - e11;
            d[0] = f_sub(m[3], m[1]);
            d[1] = f_add(m[2], m[6]);
            d[2] = f_add(m[5], m[7]);
        end
        degen = arg[SW-1] || (arg == '0);
        rad   = degen ? '0 : RAD_W'({arg[AW-1:0], {F{1'b0}}});
    end

    logic               r_f_valid;
    logic [RAD_W-1:0]   r_f_rad;
    logic [SQ_SB-1:0]   r_f_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_rad <= rad;
            r_f_sb  <= {degen, sel, d[3], d[2], d[1], d[0]};
        end
    end

    // ---------------- square root chain
    rmq_pkg::t_stage_ctl sq_ctl;
    logic                sq_valid;
    logic [RW-1:0]       sq_root;
    logic [SQ_SB-1:0]    sq_sb;

    assign sq_ctl.en    = en;
    assign sq_ctl.valid = r_f_valid;

    rmq_isqrt #(
        .RAD_W (RAD_W),
        .SB_W  (SQ_SB)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_rad   (r_f_rad),
        .i_sb    (r_f_sb),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    // ---------------- divider feed: |d| * 2^F + r over 2r, round half away
    logic [3:0][NUM_W-1:0] dv_num;
    logic [3:0]            dv_neg;
    logic [DEN_W-1:0]      dv_den;

    for (genvar k = 0; k < 4; k++) begin : g_feed
        logic signed [DDW-1:0] dk;
        logic [DDW-1:0]        mag;
        assign dk        = sq_sb[k*DDW +: DDW];
        assign dv_neg[k] = dk[DDW-1];
        assign mag       = dk[DDW-1] ? DDW'(-dk) : DDW'(dk);
        assign dv_num[k] = NUM_W'({mag, {F{1'b0}}}) + NUM_W'(sq_root);
    end
    assign dv_den = {sq_root, 1'b0};

    rmq_pkg::t_stage_ctl   dv_ctl;
    logic                  dv_valid;
    logic [3:0][NUM_W-1:0] dv_quo;
    logic [DV_SB-1:0]      dv_sb;

    assign dv_ctl.en    = en;
    assign dv_ctl.valid = sq_valid;

    rmq_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .LANES (4),
        .SB_W  (DV_SB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dv_ctl),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_sb    ({sq_sb[SQ_SB-1 -: 3], dv_neg, sq_root}),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_sb    (dv_sb)
    );

    // ---------------- output stage: own component, saturation, zeroing
    logic          o_degen;
    logic [1:0]    o_sel;
    logic [3:0]    o_neg;
    logic [RW-1:0] o_root;
    logic [RW:0]   own;
    logic [DW-1:0] comp [4];

    assign o_degen = dv_sb[DV_SB-1];
    assign o_sel   = dv_sb[DV_SB-2 -: 2];
    assign o_neg   = dv_sb[RW +: 4];
    assign o_root  = dv_sb[RW-1:0];
    assign own     = ({1'b0, o_root} + (RW+1)'(1)) >> 1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (o_degen) begin
                comp[k] = '0;
            end else if (o_sel == 2'(k)) begin
                comp[k] = (NUM_W'(own) > POS_MAX) ? POS_MAX[DW-1:0] : own[DW-1:0];
            end else if (o_neg[k]) begin
                comp[k] = (dv_quo[k] > NEG_MAX) ? NEG_MAX[DW-1:0]
                                                : DW'(-dv_quo[k][DW-1:0]);
            end else begin
                comp[k] = (dv_quo[k] > POS_MAX) ? POS_MAX[DW-1:0] : dv_quo[k][DW-1:0];
            end
        end
    end

    logic [DW-1:0] r_q [4];
    logic [1:0]    r_case;
    logic          r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q     <= comp;
            r_case  <= o_sel;
            r_degen <= o_degen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TD'({r_q[3], r_q[2], r_q[1], r_q[0]});
    assign o_m_tuser  = {r_degen, r_case};

`ifndef SYNTHESIS
    // a degenerate word carries a zero quaternion
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_degen) |-> (r_q[0] == '0 && r_q[1] == '0 &&
                                      r_q[2] == '0 && r_q[3] == '0))
        else $error("degenerate word with nonzero quaternion");

    // the trace branch always has a positive root argument
    a_trace_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_case == rmq_pkg::CASE_TRACE) |-> !r_degen)
        else $error("trace branch flagged degenerate");

    // the branch's own component is never negative
    a_own_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_degen) |-> !r_q[r_case][DW-1])
        else $error("own component negative");

    // a frozen pipeline keeps the pending output word valid, with its branch and flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_case) &&
                                          $stable(r_degen)))
        else $error("output word changed during stall");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
// matrix words go in on the slave stream in bursts with random gaps, while
// the master side stalls on its own random pattern. every accepted matrix is
// run through a local model of the fixed-point conversion, and the predicted
// quaternion word is queued. each result word is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW    = 16;
    localparam int FB    = 14;
    localparam int SW    = ((9*DW+7)/8)*8;
    localparam int MW    = ((4*DW+7)/8)*8;
    localparam int LATENCY = 60;

    typedef logic signed [DW-1:0] t_elem;
    typedef t_elem t_mat [9];

    typedef struct packed {
        logic [1:0] branch;
        logic       degen;
        t_elem      w, x, y, z;
    } t_quat;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, low bits first
    logic [SW-1:0]   i_s_tdata = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    // quat_w quat_x quat_y quat_z, low bits first
    logic [MW-1:0]   o_m_tdata;
    // case_taken[1:0], degenerate[2]
    logic [2:0]      o_m_tuser;

    t_quat  quat_expected [$];
    int     errors = 0;
    int     words_in = 0;
    int     words_out = 0;
    int     degen_seen = 0;
    int     branch_seen [4] = '{0, 0, 0, 0};
    bit     stall_enable = 1'b1;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_elem clamp(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (DW-1)) - 1;
        lo = -hi - 1;
        if (v > hi) return t_elem'(hi);
        if (v < lo) return t_elem'(lo);
        return t_elem'(v);
    endfunction

    // d * 2^FB / (2r), rounded with ties away from zero
    function automatic longint root_quotient(longint d, longint unsigned r);
        longint unsigned mag, den, q;
        mag = (d < 0) ? longint'(-d) : d;
        den = r * 2;
        q = ((mag << FB) + den / 2) / den;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat quat_of_matrix(t_mat m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, trace, arg;
        longint d [4];
        longint unsigned r;
        t_elem comp [4];
        t_quat res;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        trace = a00 + a11 + a22;
        d = '{0, 0, 0, 0};
        comp = '{0, 0, 0, 0};
        res.degen = 1'b0;
        if (trace > 0) begin
            res.branch = rmq_pkg::CASE_TRACE;
            arg = (64'sd1 <<< FB) + trace;
            d[1] = a21 - a12; d[2] = a02 - a20; d[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            res.branch = rmq_pkg::CASE_M00;
            arg = (64'sd1 <<< FB) + a00 - a11 - a22;
            d[0] = a21 - a12; d[2] = a01 + a10; d[3] = a02 + a20;
        end else if (a11 > a22) begin
            res.branch = rmq_pkg::CASE_M11;
            arg = (64'sd1 <<< FB) + a11 - a00 - a22;
            d[0] = a02 - a20; d[1] = a01 + a10; d[3] = a12 + a21;
        end else begin
            res.branch = rmq_pkg::CASE_M22;
            arg = (64'sd1 <<< FB) + a22 - a00 - a11;
            d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a12 + a21;
        end
        if (arg <= 0) begin
            res.degen = 1'b1;
        end else begin
            r = int_sqrt(longint'(arg) << FB);
            for (int k = 0; k < 4; k++) begin
                if (k == res.branch) comp[k] = clamp(longint'((r + 1) >> 1));
                else comp[k] = clamp(root_quotient(d[k], r));
            end
        end
        res.w = comp[0]; res.x = comp[1]; res.y = comp[2]; res.z = comp[3];
        return res;
    endfunction

    // send one matrix word, honoring the handshake
    task automatic send_matrix(t_mat m);
        logic [SW-1:0] word;
        word = '0;
        for (int k = 0; k < 9; k++) word[k*DW +: DW] = m[k];
        i_s_tdata  <= word;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        quat_expected.push_back(quat_of_matrix(m));
        words_in++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function automatic t_elem rand_elem();
        return t_elem'($urandom);
    endfunction

    // rotation-like matrix: diagonal near +-1, small off-diagonal terms
    function automatic t_mat rand_rotation_like();
        t_mat m;
        int mag;
        for (int k = 0; k < 9; k++) begin
            if (k % 4 == 0) begin
                mag = int'($urandom_range(12000, 16384));
                m[k] = t_elem'(($urandom_range(0, 1) == 0) ? mag : -mag);
            end else begin
                m[k] = t_elem'(int'($urandom_range(0, 8192)) - 4096);
            end
        end
        return m;
    endfunction

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (quat_expected.size() != 0);
    endtask

    // identity, negated diagonals, extremes and each branch
    task automatic test_directed();
        t_mat m;
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};     send_matrix(m);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};   send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};   send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};   send_matrix(m);
        // ties fall to the later branch
        m = '{0, 100, 200, 300, 0, 400, 500, 600, 0};     send_matrix(m);
        m = '{-5000, 1, 2, 3, 0, 4, 5, 6, -5000};         send_matrix(m);
        // extreme diagonals whose root arguments are still positive
        m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};  send_matrix(m);
        m = '{0, 0, 0, 0, 32767, 0, 0, 0, 32767};         send_matrix(m);
        // extreme element values and large off-diagonal terms
        m = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767};
        send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768};
        send_matrix(m);
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(m);
        m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_matrix(m);
        m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};   send_matrix(m);
        m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};     send_matrix(m);
        idle_gap(1);
    endtask

    // random matrices sent in bursts with gaps
    task automatic test_random(int count);
        t_mat m;
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int k = 0; k < 9; k++) m[k] = rand_elem();
                end else begin
                    m = rand_rotation_like();
                end
                send_matrix(m);
                burst--; count--;
            end
            idle_gap($urandom_range(0, 6));
        end
    endtask

    // receiver stalls in a random pattern, with stall-free stretches
    always @(negedge i_clk) begin
        if (!stall_enable) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_quat want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.w = o_m_tdata[0 +: DW];
            got.x = o_m_tdata[DW +: DW];
            got.y = o_m_tdata[2*DW +: DW];
            got.z = o_m_tdata[3*DW +: DW];
            got.branch = o_m_tuser[1:0];
            got.degen = o_m_tuser[2];
            words_out++;
            if (quat_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h user %h", $time, o_m_tdata, o_m_tuser);
            end else begin
                want = quat_expected.pop_front();
                branch_seen[got.branch]++;
                if (got.degen) degen_seen++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected w %0d x %0d y %0d z %0d br %0d dg %0d",
                             $time, want.w, want.x, want.y, want.z, want.branch, want.degen);
                    $display("%0t:          actual   w %0d x %0d y %0d z %0d br %0d dg %0d",
                             $time, got.w, got.x, got.y, got.z, got.branch, got.degen);
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(700);
        // hold off until the pipeline is empty
        drain_results();
        stall_enable = 1'b0;
        test_random(600);
        stall_enable = 1'b1;
        test_random(700);
        drain_results();
        repeat (LATENCY) @(negedge i_clk);
        $display("tb: %0d matrices in, %0d quaternions out, %0d degenerate", words_in,
                 words_out, degen_seen);
        $display("tb: branches trace %0d m00 %0d m11 %0d m22 %0d", branch_seen[0],
                 branch_seen[1], branch_seen[2], branch_seen[3]);
        if (errors == 0 && quat_expected.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/rmq_pkg.sv
sv/rmq_isqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
sim/tb.sv
